/* rtl/core/khl_pkg.sv */
// shared constants, types and keyword tables for the keyword hash lookup
`timescale 1ns / 1ps

package khl_pkg;

  localparam int MAX_NAME_BYTES = 63;
  localparam int SLOT_COUNT     = 64;
  localparam int KEYWORD_COUNT  = 35;
  localparam int KEYWORD_MAX    = 10;

  localparam int LEN_W  = $clog2(MAX_NAME_BYTES + 2);
  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int ID_W   = 6;
  localparam int KLEN_W = $clog2(KEYWORD_MAX + 1);

  localparam logic [31:0] HASH_BASIS = 32'd2166136261;
  localparam logic [31:0] HASH_PRIME = 32'd16777619;

  typedef logic [8*KEYWORD_MAX-1:0] kw_text_t;
  typedef logic [KLEN_W-1:0]        kw_len_t;
  typedef logic [ID_W-1:0]          slot_table_t [SLOT_COUNT];

  // keyword text, first character in the most significant used byte
  localparam kw_text_t KW_TEXT [KEYWORD_COUNT] = '{
    kw_text_t'("h1"), kw_text_t'("h2"), kw_text_t'("h3"), kw_text_t'("h4"),
    kw_text_t'("h5"), kw_text_t'("h6"), kw_text_t'("p"), kw_text_t'("div"),
    kw_text_t'("br"), kw_text_t'("b"), kw_text_t'("strong"), kw_text_t'("i"),
    kw_text_t'("em"), kw_text_t'("del"), kw_text_t'("s"), kw_text_t'("a"),
    kw_text_t'("img"), kw_text_t'("code"), kw_text_t'("pre"), kw_text_t'("hr"),
    kw_text_t'("iframe"), kw_text_t'("video"), kw_text_t'("embed"),
    kw_text_t'("object"), kw_text_t'("ul"), kw_text_t'("ol"), kw_text_t'("li"),
    kw_text_t'("blockquote"), kw_text_t'("table"), kw_text_t'("tr"),
    kw_text_t'("th"), kw_text_t'("td"), kw_text_t'("center"),
    kw_text_t'("details"), kw_text_t'("summary")
  };

  localparam kw_len_t KW_LEN [KEYWORD_COUNT] = '{
    kw_len_t'(2), kw_len_t'(2), kw_len_t'(2), kw_len_t'(2), kw_len_t'(2),
    kw_len_t'(2), kw_len_t'(1), kw_len_t'(3), kw_len_t'(2), kw_len_t'(1),
    kw_len_t'(6), kw_len_t'(1), kw_len_t'(2), kw_len_t'(3), kw_len_t'(1),
    kw_len_t'(1), kw_len_t'(3), kw_len_t'(4), kw_len_t'(3), kw_len_t'(2),
    kw_len_t'(6), kw_len_t'(5), kw_len_t'(5), kw_len_t'(6), kw_len_t'(2),
    kw_len_t'(2), kw_len_t'(2), kw_len_t'(10), kw_len_t'(5), kw_len_t'(2),
    kw_len_t'(2), kw_len_t'(2), kw_len_t'(6), kw_len_t'(7), kw_len_t'(7)
  };

  // character j of a keyword of length len
  function automatic logic [7:0] kw_char(kw_text_t text, int len, int j);
    return text[8*(len-1-j) +: 8];
  endfunction

  function automatic logic [31:0] fnv_step(logic [31:0] h, logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    return 32'(x * HASH_PRIME);
  endfunction

  // open addressing table with linear probing, worked out at elaboration
  function automatic slot_table_t build_slot_table();
    slot_table_t tbl;
    logic [31:0] h;
    int          slot;
    int          walked;
    for (int s = 0; s < SLOT_COUNT; s++) tbl[s] = '0;
    for (int i = 0; i < KEYWORD_COUNT; i++) begin
      h = HASH_BASIS;
      for (int j = 0; j < int'(KW_LEN[i]); j++) begin
        h = fnv_step(h, kw_char(KW_TEXT[i], int'(KW_LEN[i]), j));
      end
      slot = int'(h % SLOT_COUNT);
      walked = 0;
      while (walked < SLOT_COUNT && tbl[slot] != '0) begin
        slot = (slot + 1) % SLOT_COUNT;
        walked++;
      end
      if (tbl[slot] == '0) tbl[slot] = ID_W'(i + 1);
    end
    return tbl;
  endfunction

  localparam slot_table_t SLOT_TABLE = build_slot_table();

  typedef struct packed {
    logic accept;      // input transfer this cycle
    logic probe;       // examine the current slot
    logic emit_long;   // deliver the too-long result
    logic emit_probe;  // deliver the probe result
  } khl_cmd_t;

  typedef struct packed {
    logic len_full;    // stored length has reached the byte limit
    logic slot_empty;  // current slot holds no keyword
    logic slot_hit;    // current slot keyword matches the name
  } khl_status_t;

endpackage

/* rtl/core/keyword_hash_lookup.sv */
// top level of the keyword hash lookup: controller and datapath
`timescale 1ns / 1ps

// Keyword lookup over a tag name delivered one byte per transfer, the final
// byte flagged by in_last_byte. A byte is taken on a rising edge with start
// high and busy low. Bytes are folded to lower case and run through a 32-bit
// FNV-1a hash; busy stays low through the middle bytes, so a new byte may
// follow every cycle. After the last byte the block walks a fixed 64-slot
// linear-probing table, one slot per cycle, with busy high until the walk
// reaches a slot that matches or is empty; the result then appears on
// out_keyword_id / out_too_long with out_valid high for exactly one cycle,
// in the cycle after the walk ends. The receiver cannot stall: each result
// must be taken in the cycle it is shown. A name longer than 63 bytes gives
// id 0 with out_too_long set in the cycle after its last byte, without a
// walk. A miss gives id 0.

module keyword_hash_lookup import khl_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  logic [7:0]      in_name_byte,
  input  logic            in_last_byte,
  output logic            out_valid,
  output logic [ID_W-1:0] out_keyword_id,
  output logic            out_too_long
);

  khl_cmd_t    cmd;
  khl_status_t status;

  // sequencing of byte transfers and the slot walk
  khl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .last_byte (in_last_byte),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy)
  );

  // hash, stored prefix, table compare and result register
  khl_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .name_byte    (in_name_byte),
    .last_byte    (in_last_byte),
    .status       (status),
    .res_valid    (out_valid),
    .res_id       (out_keyword_id),
    .res_too_long (out_too_long)
  );

endmodule

/* rtl/core/khl_ctrl.sv */
// controller state machine for the keyword hash lookup
`timescale 1ns / 1ps

module khl_ctrl import khl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        last_byte,
  input  khl_status_t status,
  output khl_cmd_t    cmd,
  output logic        busy
);

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_PROBE = 1'b1;

  logic state_r;
  logic state_nxt;
  logic accept;
  logic probe_done;

  assign busy       = (state_r == S_PROBE);
  assign accept     = start && !busy;
  assign probe_done = status.slot_empty || status.slot_hit;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && last_byte && !status.len_full) state_nxt = S_PROBE;
      end
      S_PROBE: begin
        if (probe_done) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign cmd.accept     = accept;
  assign cmd.probe      = busy;
  assign cmd.emit_long  = accept && last_byte && status.len_full;
  assign cmd.emit_probe = busy && probe_done;

endmodule

/* rtl/core/khl_datapath.sv */
// hash, name prefix, slot walk and result registers
`timescale 1ns / 1ps

module khl_datapath import khl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  khl_cmd_t         cmd,
  input  logic [7:0]       name_byte,
  input  logic             last_byte,
  output khl_status_t      status,
  output logic             res_valid,
  output logic [ID_W-1:0]  res_id,
  output logic             res_too_long
);

  logic [31:0]       hash_r;
  logic [31:0]       hash_nxt;
  logic [LEN_W-1:0]  len_r;
  logic [LEN_W-1:0]  len_nxt;
  logic [LEN_W-1:0]  probe_len_r;
  logic [SLOT_W-1:0] slot_r;
  logic [7:0]        prefix_r [KEYWORD_MAX];
  logic [7:0]        folded;
  logic [ID_W-1:0]   cur_id;
  kw_text_t          cur_text;
  kw_len_t           cur_len;
  logic [KEYWORD_MAX-1:0] byte_ok;
  logic              valid_r;
  logic [ID_W-1:0]   id_r;
  logic              long_r;

  assign folded   = (name_byte >= 8'h41 && name_byte <= 8'h5a) ? name_byte + 8'h20 : name_byte;
  assign hash_nxt = fnv_step(hash_r, folded);
  assign len_nxt  = (len_r < LEN_W'(MAX_NAME_BYTES)) ? len_r + LEN_W'(1)
                                                      : LEN_W'(MAX_NAME_BYTES + 1);

  assign status.len_full = (len_r >= LEN_W'(MAX_NAME_BYTES));

  // keyword in the slot under examination
  assign cur_id = SLOT_TABLE[slot_r];
  always_comb begin
    cur_text = '0;
    cur_len  = '0;
    if (cur_id != '0 && int'(cur_id) <= KEYWORD_COUNT) begin
      cur_text = KW_TEXT[cur_id - ID_W'(1)];
      cur_len  = KW_LEN[cur_id - ID_W'(1)];
    end
  end

  always_comb begin
    for (int j = 0; j < KEYWORD_MAX; j++) begin
      byte_ok[j] = (j >= int'(cur_len)) ||
                   (prefix_r[j] == kw_char(cur_text, int'(cur_len), j));
    end
  end

  assign status.slot_empty = (cur_id == '0);
  assign status.slot_hit   = (cur_id != '0) && (LEN_W'(cur_len) == probe_len_r) && (&byte_ok);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r  <= HASH_BASIS;
      len_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.emit_long || cmd.emit_probe;
      if (cmd.accept) begin
        hash_r <= last_byte ? HASH_BASIS : hash_nxt;
        len_r  <= last_byte ? '0 : len_nxt;
      end
    end
  end

  // first bytes of the name, one fixed lane per position
  always_ff @(posedge clk) begin
    for (int j = 0; j < KEYWORD_MAX; j++) begin
      if (cmd.accept && len_r == LEN_W'(j)) prefix_r[j] <= folded;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      slot_r      <= hash_nxt[SLOT_W-1:0];
      probe_len_r <= len_nxt;
    end else if (cmd.probe) begin
      slot_r <= slot_r + SLOT_W'(1);
    end
    if (cmd.emit_long) begin
      id_r   <= '0;
      long_r <= 1'b1;
    end else if (cmd.emit_probe) begin
      id_r   <= status.slot_hit ? cur_id : '0;
      long_r <= 1'b0;
    end
  end

  assign res_valid    = valid_r;
  assign res_id       = id_r;
  assign res_too_long = long_r;

endmodule

/* sim/tb.sv */
// self-checking testbench for the keyword hash lookup block
`timescale 1ns / 1ps

module tb;
  import khl_pkg::*;

  // keyword ids that can be read straight off the keyword list
  localparam logic [ID_W-1:0] ID_NONE       = '0;
  localparam logic [ID_W-1:0] ID_H1         = ID_W'(1);
  localparam logic [ID_W-1:0] ID_BLOCKQUOTE = ID_W'(28);
  localparam logic [ID_W-1:0] ID_SUMMARY    = ID_W'(35);

  // no transfer for this many cycles means the block has hung
  localparam int STALL_LIMIT  = 1000;
  // covers the longest probe chain and the result, with margin
  localparam int SETTLE_CYCLES = SLOT_COUNT + 8;
  localparam int RANDOM_ITEMS  = 1600;

  typedef logic [7:0] name_bytes_t[$];

  typedef struct packed {
    logic [ID_W-1:0] keyword_id;
    logic            too_long;
  } lookup_result_t;

  // per name: whether the answer is typed in by hand, and that answer
  typedef struct packed {
    logic           typed;
    lookup_result_t result;
  } name_answer_t;

  // directed row: name text right aligned, first byte most significant
  typedef struct {
    logic [79:0]     text;
    int              len;
    logic            typed;
    logic [ID_W-1:0] keyword_id;
    logic            too_long;
  } name_row_t;

  localparam int ROW_COUNT = 7;

  // directed names: plain and upper-case hits, the longest keyword, the byte
  // extremes, and bytes on either side of the A-Z fold range and of a-z
  name_row_t name_rows [ROW_COUNT] = '{
    '{"h1",         2,  1'b1, ID_H1,         1'b0},
    '{"SUMMARY",    7,  1'b1, ID_SUMMARY,    1'b0},
    '{"BlockQuote", 10, 1'b1, ID_BLOCKQUOTE, 1'b0},
    '{80'h00,       1,  1'b0, ID_NONE,       1'b0},
    '{80'hff,       1,  1'b0, ID_NONE,       1'b0},
    '{80'h405b607b, 4,  1'b0, ID_NONE,       1'b0},
    '{"AZ",         2,  1'b0, ID_NONE,       1'b0}
  };

  // keyword list in id order, for the lookup predictor
  string keyword_text [KEYWORD_COUNT] = '{
    "h1", "h2", "h3", "h4", "h5", "h6", "p", "div", "br", "b", "strong",
    "i", "em", "del", "s", "a", "img", "code", "pre", "hr", "iframe",
    "video", "embed", "object", "ul", "ol", "li", "blockquote",
    "table", "tr", "th", "td", "center", "details", "summary"
  };

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  logic [7:0]      in_name_byte = '0;
  logic            in_last_byte = 1'b0;
  logic            out_valid;
  logic [ID_W-1:0] out_keyword_id;
  logic            out_too_long;

  // predictor state: folded name so far, its length and running hash
  logic [7:0]  pred_name [MAX_NAME_BYTES];
  int          pred_len;
  logic [31:0] pred_hash;
  int          keyword_slots [SLOT_COUNT];

  lookup_result_t expected_lookups[$];
  name_answer_t   name_answers[$];

  int fail_count;
  int stall_cycles = 0;
  int burst_left;

  keyword_hash_lookup dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_name_byte   (in_name_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_keyword_id (out_keyword_id),
    .out_too_long   (out_too_long)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // one fnv-1a round: xor the byte in, multiply by the prime mod 2^32
  function automatic logic [31:0] fnv1a_round(logic [31:0] h, logic [7:0] b);
    return (h ^ {24'd0, b}) * HASH_PRIME;
  endfunction

  function automatic logic [7:0] fold_case(logic [7:0] b);
    return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
  endfunction

  // place the keywords in list order with linear probing
  function automatic void place_keywords();
    logic [31:0] h;
    int          slot;
    for (int s = 0; s < SLOT_COUNT; s++) keyword_slots[s] = 0;
    for (int i = 0; i < KEYWORD_COUNT; i++) begin
      h = HASH_BASIS;
      for (int j = 0; j < keyword_text[i].len(); j++) begin
        h = fnv1a_round(h, keyword_text[i][j]);
      end
      slot = int'(h % SLOT_COUNT);
      for (int w = 0; w < SLOT_COUNT && keyword_slots[slot] != 0; w++) begin
        slot = (slot + 1) % SLOT_COUNT;
      end
      if (keyword_slots[slot] == 0) keyword_slots[slot] = i + 1;
    end
  endfunction

  // walk the slot chain from the hashed slot up to a match or the first empty one
  function automatic logic [ID_W-1:0] probe_keywords();
    int slot;
    int id;
    bit same;
    slot = int'(pred_hash % SLOT_COUNT);
    for (int w = 0; w < SLOT_COUNT; w++) begin
      id = keyword_slots[slot];
      if (id == 0) return ID_NONE;
      if (keyword_text[id-1].len() == pred_len) begin
        same = 1'b1;
        for (int j = 0; j < pred_len; j++) begin
          if (keyword_text[id-1][j] != pred_name[j]) same = 1'b0;
        end
        if (same) return ID_W'(id);
      end
      slot = (slot + 1) % SLOT_COUNT;
    end
    return ID_NONE;
  endfunction

  // advance the predictor by one accepted byte; a last byte yields a result
  function automatic void predict_byte(input logic [7:0] raw, input logic last,
                                       output lookup_result_t result);
    logic [7:0] b;
    b = fold_case(raw);
    pred_hash = fnv1a_round(pred_hash, b);
    if (pred_len < MAX_NAME_BYTES) begin
      pred_name[pred_len] = b;
      pred_len++;
    end else begin
      // bytes past the limit are hashed but not kept
      pred_len = MAX_NAME_BYTES + 1;
    end
    result = '0;
    if (last) begin
      if (pred_len > MAX_NAME_BYTES) result.too_long = 1'b1;
      else result.keyword_id = probe_keywords();
      pred_len  = 0;
      pred_hash = HASH_BASIS;
    end
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // every input transfer feeds the predictor; a last byte queues its answer
  always @(posedge clk) begin
    lookup_result_t predicted;
    name_answer_t   answer;
    if (rst_n && start && !busy) begin
      predict_byte(in_name_byte, in_last_byte, predicted);
      if (in_last_byte) begin
        answer = '0;
        if (name_answers.size() != 0) answer = name_answers.pop_front();
        expected_lookups.push_back(answer.typed ? answer.result : predicted);
      end
    end
  end

  // results cannot be held off: check each one in the cycle it is shown
  always @(posedge clk) begin
    lookup_result_t want;
    if (rst_n && out_valid) begin
      if (expected_lookups.size() == 0) begin
        flag_mismatch($sformatf("result id %0d too_long %0b with none expected",
                                out_keyword_id, out_too_long));
      end else begin
        want = expected_lookups.pop_front();
        if (out_keyword_id !== want.keyword_id)
          flag_mismatch($sformatf("keyword id %0d, expected %0d",
                                  out_keyword_id, want.keyword_id));
        if (out_too_long !== want.too_long)
          flag_mismatch($sformatf("too_long %0b, expected %0b",
                                  out_too_long, want.too_long));
      end
    end
  end

  // watchdog: any transfer in either direction restarts the count
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("keyword_hash_lookup verification failed");
        $finish;
      end
    end
  end

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // lower start and wait for every queued lookup to come back
  task automatic drain_lookups();
    start <= 1'b0;
    @(posedge clk);
    while (expected_lookups.size() != 0) @(posedge clk);
  endtask

  // bursts of random length, mostly short, now and then a long unbroken run
  task automatic pace_sender();
    if (burst_left == 0) begin
      if ($urandom_range(3) == 0) burst_left = $urandom_range(40, 150);
      else burst_left = $urandom_range(1, 12);
      hold_off($urandom_range(1, 6));
    end
    burst_left--;
  endtask

  // hold start high until the byte is taken on an edge with busy low
  task automatic send_byte(input logic [7:0] b, input logic last);
    start        <= 1'b1;
    in_name_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_name(input name_bytes_t bytes, input name_answer_t answer);
    name_answers.push_back(answer);
    foreach (bytes[i]) begin
      pace_sender();
      send_byte(bytes[i], i == bytes.size() - 1);
    end
  endtask

  function automatic logic [7:0] random_letter();
    return ($urandom_range(1) ? "a" : "A") + 8'($urandom_range(25));
  endfunction

  // random name shape: mostly keywords in mixed case, then near misses,
  // arbitrary bytes, long names up to the limit and names past it
  function automatic name_bytes_t random_name();
    name_bytes_t bytes;
    string       kw;
    int          pick;
    int          len;
    pick = $urandom_range(99);
    kw   = keyword_text[$urandom_range(KEYWORD_COUNT - 1)];
    if (pick < 72) begin
      for (int j = 0; j < kw.len(); j++) begin
        if (kw[j] >= "a" && kw[j] <= "z" && $urandom_range(1))
          bytes.push_back(kw[j] - 8'd32);
        else
          bytes.push_back(kw[j]);
      end
      if (pick >= 55 && pick < 65) begin
        bytes[$urandom_range(bytes.size() - 1)] = 8'($urandom_range(255));
      end else if (pick >= 65) begin
        if (bytes.size() > 1 && $urandom_range(1)) void'(bytes.pop_back());
        else bytes.push_back(random_letter());
      end
    end else if (pick < 86) begin
      len = $urandom_range(1, 12);
      repeat (len) bytes.push_back(8'($urandom_range(255)));
    end else if (pick < 92) begin
      len = $urandom_range(1, 8);
      repeat (len) bytes.push_back(random_letter());
    end else if (pick < 96) begin
      len = $urandom_range(2) == 0 ? MAX_NAME_BYTES : $urandom_range(50, MAX_NAME_BYTES);
      repeat (len) bytes.push_back(random_letter());
    end else begin
      len = $urandom_range(MAX_NAME_BYTES + 1, MAX_NAME_BYTES + 9);
      repeat (len) bytes.push_back(8'($urandom_range(255)));
    end
    return bytes;
  endfunction

  initial begin
    name_bytes_t  bytes;
    name_answer_t answer;
    int           sent;
    int           names;
    fail_count   = 0;
    burst_left   = 0;
    pred_len     = 0;
    pred_hash    = HASH_BASIS;
    place_keywords();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (name_rows[r]) begin
      bytes = {};
      for (int j = 0; j < name_rows[r].len; j++) begin
        bytes.push_back(name_rows[r].text[8*(name_rows[r].len-1-j) +: 8]);
      end
      answer.typed             = name_rows[r].typed;
      answer.result.keyword_id = name_rows[r].keyword_id;
      answer.result.too_long   = name_rows[r].too_long;
      send_name(bytes, answer);
    end

    // random names; now and then the sender waits for the block to drain
    sent  = 0;
    names = 0;
    answer = '0;
    while (sent < RANDOM_ITEMS) begin
      bytes = random_name();
      send_name(bytes, answer);
      sent += bytes.size();
      names++;
      if (names == 50 || $urandom_range(39) == 0) drain_lookups();
    end

    drain_lookups();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("keyword_hash_lookup verification clean");
    end else begin
      $display("keyword_hash_lookup verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/khl_pkg.sv
rtl/core/khl_ctrl.sv
rtl/core/khl_datapath.sv
rtl/core/keyword_hash_lookup.sv
sim/tb.sv
